>>> rtl/swc_pkg.sv
// ============================================================================
// swc_pkg
// Shared widths, constants, codes and types for the window coefficient block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

    localparam int MAX_LENGTH     = 8192;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COSINE_STAGES  = 18;

    localparam int KIND_W  = 3;
    localparam int LEN_W   = 14;
    localparam int IDX_W   = 13;
    localparam int COEF_W  = COEF_FRAC_BITS + 1;
    localparam int QUOT_W  = 31;
    localparam int NUM_W   = QUOT_W + LEN_W;
    localparam int CW      = 34;
    localparam int C_W     = 32;
    localparam int PROD_W  = 64;
    localparam int RND_SH  = 30 - COEF_FRAC_BITS;

    localparam logic [31:0]          PI_Q30      = 32'd3373259426;
    localparam logic signed [CW-1:0] ONE_Q30     = CW'(64'sd1073741824);
    localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
    localparam logic signed [CW-1:0] HAMMING_A0  = CW'(64'sd579820585);
    localparam logic signed [C_W-1:0] HAMMING_A1 = C_W'(64'sd493921239);
    localparam logic signed [CW-1:0] BLACKMAN_A0 = CW'(64'sd450971566);
    localparam logic signed [C_W-1:0] BLACKMAN_A2 = C_W'(64'sd85899346);

    typedef enum logic [KIND_W-1:0] {
        KIND_HANN      = 3'd0,
        KIND_HAMMING   = 3'd1,
        KIND_BLACKMAN  = 3'd2,
        KIND_BARTLETT  = 3'd3,
        KIND_RECT      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_KIND     = 2'd0,
        REG_LENGTH   = 2'd1,
        REG_PERIODIC = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic oor;
        logic unity;
        logic neg;
    } side_t;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] v;
        begin
            case (i)
                0:  v = CW'(64'sd843314856);
                1:  v = CW'(64'sd497837829);
                2:  v = CW'(64'sd263043836);
                3:  v = CW'(64'sd133525158);
                4:  v = CW'(64'sd67021686);
                5:  v = CW'(64'sd33543515);
                6:  v = CW'(64'sd16775850);
                7:  v = CW'(64'sd8388437);
                8:  v = CW'(64'sd4194282);
                9:  v = CW'(64'sd2097149);
                10: v = CW'(64'sd1048575);
                11: v = CW'(64'sd524287);
                12: v = CW'(64'sd262143);
                13: v = CW'(64'sd131071);
                14: v = CW'(64'sd65535);
                15: v = CW'(64'sd32767);
                16: v = CW'(64'sd16383);
                17: v = CW'(64'sd8191);
                18: v = CW'(64'sd4095);
                19: v = CW'(64'sd2047);
                20: v = CW'(64'sd1023);
                21: v = CW'(64'sd511);
                22: v = CW'(64'sd255);
                23: v = CW'(64'sd127);
                24: v = CW'(64'sd63);
                25: v = CW'(64'sd31);
                26: v = CW'(64'sd15);
                27: v = CW'(64'sd7);
                28: v = CW'(64'sd3);
                29: v = CW'(64'sd1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/swc_div.sv
// ============================================================================
// swc_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module swc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    input  wire logic                        in_valid,
    input  wire logic [swc_pkg::NUM_W-1:0]   num,
    input  wire logic [swc_pkg::LEN_W-1:0]   den,
    input  wire swc_pkg::side_t              side_in,
    output logic                             out_valid,
    output logic [swc_pkg::QUOT_W-1:0]       quot,
    output swc_pkg::side_t                   side_out
);
    import swc_pkg::*;

    logic              valid_reg [QUOT_W];
    logic [LEN_W-1:0]  rem_reg   [QUOT_W];
    logic [QUOT_W-1:0] low_reg   [QUOT_W];
    logic [QUOT_W-1:0] quot_reg  [QUOT_W];
    logic [LEN_W-1:0]  den_reg   [QUOT_W];
    side_t             side_reg  [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
        logic              v_in;
        logic [LEN_W-1:0]  rem_in;
        logic [QUOT_W-1:0] low_in;
        logic [QUOT_W-1:0] q_in;
        logic [LEN_W-1:0]  den_in;
        side_t             side_i;
        logic [LEN_W:0]    trial;
        logic              ge;
        logic [LEN_W:0]    diff;

        if (s == 0) begin : g_first
            always_comb
            begin
                v_in   = in_valid;
                rem_in = num[NUM_W-1:QUOT_W];
                low_in = num[QUOT_W-1:0];
                q_in   = '0;
                den_in = den;
                side_i = side_in;
            end
        end else begin : g_next
            always_comb
            begin
                v_in   = valid_reg[s-1];
                rem_in = rem_reg[s-1];
                low_in = low_reg[s-1];
                q_in   = quot_reg[s-1];
                den_in = den_reg[s-1];
                side_i = side_reg[s-1];
            end
        end

        always_comb
        begin
            trial = {rem_in, low_in[QUOT_W-1]};
            ge    = trial >= {1'b0, den_in};
            diff  = trial - {1'b0, den_in};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s]  <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
                low_reg[s]  <= {low_in[QUOT_W-2:0], 1'b0};
                quot_reg[s] <= {q_in[QUOT_W-2:0], ge};
                den_reg[s]  <= den_in;
                side_reg[s] <= side_i;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quot      = quot_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

`default_nettype wire

>>> rtl/spectral_window_coefficient_top.sv
// ============================================================================
// spectral_window_coefficient_top
// Window coefficient generator: Hann, Hamming, Blackman, Bartlett, rectangular.
// ============================================================================
// Usage:
//   Write window_kind (index 0), window_length (index 1) and periodic_mode
//   (index 2) through cfg_write/cfg_index/cfg_data while the block is idle.
//   Present a sample_index beat with in_valid; it is taken at a clock edge
//   where in_stall is low. The matching coefficient and index_out_of_range
//   beat appears on out_valid once it has passed the pipeline below and is
//   taken when out_stall is low.
//   Throughput is one beat per cycle unless stalled: the path is a fixed
//   pipeline of an index fold stage, a numerator multiply stage, a 31-stage
//   divider that yields one quotient bit per stage, an 18-stage cosine
//   rotation and three window arithmetic stages ending in the output register.
//   When out_stall is high while a beat waits, the whole pipeline holds and
//   in_stall rises; nothing is dropped or repeated.
//   Reset clears all valid bits and loads Hann, length 1024, symmetric.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module spectral_window_coefficient_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [swc_pkg::LEN_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [swc_pkg::IDX_W-1:0]      sample_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [swc_pkg::COEF_W-1:0]          coefficient,
    output logic                                index_out_of_range
);
    import swc_pkg::*;

    logic [KIND_W-1:0] window_kind_reg;
    logic [LEN_W-1:0]  window_length_reg;
    logic              periodic_mode_reg;
    logic              advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_kind_reg   <= KIND_HANN;
            window_length_reg <= LEN_W'(1024);
            periodic_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KIND:     window_kind_reg   <= cfg_data[KIND_W-1:0];
                REG_LENGTH:   window_length_reg <= cfg_data;
                REG_PERIODIC: periodic_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    logic out_valid_reg;
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // fold stage
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   n_pts;
    logic [LEN_W-1:0]   d_pts;
    logic [LEN_W-1:0]   k_ext;
    logic [LEN_W-1:0]   dk;
    logic [LEN_W-1:0]   m_val;
    logic [LEN_W+1:0]   m_x4;
    logic [LEN_W-1:0]   u_val;
    side_t              side_s1;

    always_comb
    begin
        len   = (window_length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                         : window_length_reg;
        k_ext = LEN_W'(sample_index);
        n_pts = len + LEN_W'(periodic_mode_reg);
        d_pts = n_pts - LEN_W'(1);
        dk    = d_pts - k_ext;
        m_val = (k_ext < dk) ? k_ext : dk;
        m_x4  = {m_val, 2'b00};
        side_s1.oor   = k_ext >= len;
        side_s1.neg   = m_x4 > {2'b00, d_pts};
        side_s1.unity = (n_pts <= LEN_W'(1)) || (window_kind_reg > KIND_BARTLETT);
        u_val = side_s1.neg ? (d_pts - {m_val[LEN_W-2:0], 1'b0})
                            : {m_val[LEN_W-2:0], 1'b0};
    end

    logic             s1_valid_reg;
    logic [LEN_W-1:0] s1_m_reg;
    logic [LEN_W-1:0] s1_u_reg;
    logic [LEN_W-1:0] s1_d_reg;
    side_t            s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_m_reg    <= m_val;
            s1_u_reg    <= u_val;
            s1_d_reg    <= d_pts;
            s1_side_reg <= side_s1;
        end
    end

    // numerator stage
    logic [NUM_W-1:0] num_next;

    always_comb
    begin
        if (window_kind_reg == KIND_BARTLETT)
        begin
            num_next = NUM_W'({s1_m_reg, 1'b0}) << 30;
        end
        else
        begin
            num_next = NUM_W'(s1_u_reg) * NUM_W'(PI_Q30);
        end
    end

    logic             s2_valid_reg;
    logic [NUM_W-1:0] s2_num_reg;
    logic [LEN_W-1:0] s2_d_reg;
    side_t            s2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_num_reg  <= num_next;
            s2_d_reg    <= s1_d_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    logic              dv_valid;
    logic [QUOT_W-1:0] dv_quot;
    side_t             dv_side;

    swc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s2_valid_reg),
        .num      (s2_num_reg),
        .den      (s2_d_reg),
        .side_in  (s2_side_reg),
        .out_valid(dv_valid),
        .quot     (dv_quot),
        .side_out (dv_side)
    );

    // cosine rotation
    logic                 cr_valid_reg [COSINE_STAGES];
    logic signed [CW-1:0] cr_x_reg     [COSINE_STAGES];
    logic signed [CW-1:0] cr_y_reg     [COSINE_STAGES];
    logic signed [CW-1:0] cr_z_reg     [COSINE_STAGES];
    logic [QUOT_W-1:0]    cr_q_reg     [COSINE_STAGES];
    side_t                cr_side_reg  [COSINE_STAGES];

    for (genvar s = 0; s < COSINE_STAGES; s++) begin : g_rot
        logic                 v_in;
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic [QUOT_W-1:0]    q_in;
        side_t                side_i;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        if (s == 0) begin : g_first
            always_comb
            begin
                v_in   = dv_valid;
                x_in   = GAIN_Q30;
                y_in   = '0;
                z_in   = CW'($signed({1'b0, dv_quot}));
                q_in   = dv_quot;
                side_i = dv_side;
            end
        end else begin : g_next
            always_comb
            begin
                v_in   = cr_valid_reg[s-1];
                x_in   = cr_x_reg[s-1];
                y_in   = cr_y_reg[s-1];
                z_in   = cr_z_reg[s-1];
                q_in   = cr_q_reg[s-1];
                side_i = cr_side_reg[s-1];
            end
        end

        always_comb
        begin
            xs = x_in >>> s;
            ys = y_in >>> s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cr_valid_reg[s] <= 1'b0;
            end
            else if (advance)
            begin
                cr_valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!z_in[CW-1])
                begin
                    cr_x_reg[s] <= x_in - ys;
                    cr_y_reg[s] <= y_in + xs;
                    cr_z_reg[s] <= z_in - atan_q30(s);
                end
                else
                begin
                    cr_x_reg[s] <= x_in + ys;
                    cr_y_reg[s] <= y_in - xs;
                    cr_z_reg[s] <= z_in + atan_q30(s);
                end
                cr_q_reg[s]    <= q_in;
                cr_side_reg[s] <= side_i;
            end
        end
    end

    // clamp, sign and first products
    logic signed [CW-1:0]  x_last;
    logic signed [CW-1:0]  x_clamp;
    logic signed [C_W-1:0] c_val;

    always_comb
    begin
        x_last = cr_x_reg[COSINE_STAGES-1];
        if (x_last[CW-1])
        begin
            x_clamp = '0;
        end
        else if (x_last > ONE_Q30)
        begin
            x_clamp = ONE_Q30;
        end
        else
        begin
            x_clamp = x_last;
        end
        c_val = cr_side_reg[COSINE_STAGES-1].neg ? C_W'(-x_clamp) : C_W'(x_clamp);
    end

    logic                     w1_valid_reg;
    logic signed [C_W-1:0]    w1_c_reg;
    logic signed [PROD_W-1:0] w1_ham_reg;
    logic signed [PROD_W-1:0] w1_sq_reg;
    logic [QUOT_W-1:0]        w1_q_reg;
    side_t                    w1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w1_valid_reg <= cr_valid_reg[COSINE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w1_c_reg    <= c_val;
            w1_ham_reg  <= PROD_W'(HAMMING_A1) * PROD_W'(c_val);
            w1_sq_reg   <= PROD_W'(c_val) * PROD_W'(c_val);
            w1_q_reg    <= cr_q_reg[COSINE_STAGES-1];
            w1_side_reg <= cr_side_reg[COSINE_STAGES-1];
        end
    end

    // second product and partial window terms
    logic signed [CW-1:0]  c_ext;
    logic signed [C_W-1:0] c2_val;

    always_comb
    begin
        c_ext  = CW'(w1_c_reg);
        c2_val = C_W'((w1_sq_reg >>> 29) - PROD_W'(ONE_Q30));
    end

    logic                     w2_valid_reg;
    logic signed [CW-1:0]     w2_hann_reg;
    logic signed [CW-1:0]     w2_ham_reg;
    logic signed [CW-1:0]     w2_blk_reg;
    logic signed [PROD_W-1:0] w2_blk_prod_reg;
    logic [QUOT_W-1:0]        w2_q_reg;
    side_t                    w2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w2_valid_reg <= w1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w2_hann_reg     <= (ONE_Q30 - c_ext) >>> 1;
            w2_ham_reg      <= HAMMING_A0 - CW'(w1_ham_reg >>> 30);
            w2_blk_reg      <= BLACKMAN_A0 - (c_ext >>> 1);
            w2_blk_prod_reg <= PROD_W'(BLACKMAN_A2) * PROD_W'(c2_val);
            w2_q_reg        <= w1_q_reg;
            w2_side_reg     <= w1_side_reg;
        end
    end

    // select, clamp and round
    logic signed [CW-1:0] w_sel;
    logic signed [CW-1:0] w_clamp;
    logic [CW:0]          w_rnd;
    logic [CW:0]          coef_full;
    logic [COEF_W-1:0]    coef_next;

    always_comb
    begin
        case (kind_t'(window_kind_reg))
            KIND_HANN:     w_sel = w2_hann_reg;
            KIND_HAMMING:  w_sel = w2_ham_reg;
            KIND_BLACKMAN: w_sel = w2_blk_reg + CW'(w2_blk_prod_reg >>> 30);
            KIND_BARTLETT: w_sel = CW'($signed({1'b0, w2_q_reg}));
            default:       w_sel = ONE_Q30;
        endcase
        if (w2_side_reg.unity)
        begin
            w_sel = ONE_Q30;
        end
        if (w_sel[CW-1])
        begin
            w_clamp = '0;
        end
        else if (w_sel > ONE_Q30)
        begin
            w_clamp = ONE_Q30;
        end
        else
        begin
            w_clamp = w_sel;
        end
        w_rnd     = {w_clamp, 1'b0} + ((CW+1)'(1) << RND_SH);
        coef_full = w_rnd >> (RND_SH + 1);
        if (coef_full > ((CW+1)'(1) << COEF_FRAC_BITS))
        begin
            coef_full = (CW+1)'(1) << COEF_FRAC_BITS;
        end
        coef_next = w2_side_reg.oor ? '0 : coef_full[COEF_W-1:0];
    end

    logic [COEF_W-1:0] coef_reg;
    logic              oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= w2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            coef_reg <= coef_next;
            oor_reg  <= w2_side_reg.oor;
        end
    end

    assign out_valid          = out_valid_reg;
    assign coefficient        = coef_reg;
    assign index_out_of_range = oor_reg;

endmodule

`default_nettype wire
